// ===== rtl/pbs_pkg.sv =====
// ============================================================================
// pbs_pkg - shared types and constants for the periodic burst scheduler
// Holds the transaction payload structs, the configuration bundle and the
// range limits that the configuration and scheduling logic both use.
// ============================================================================
package pbs_pkg;

    // Operation codes carried by an input transaction.
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd3;
    localparam int CFG_DATA_W = 22;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int LEN_W   = 22;
    localparam int IVL_W   = 13;
    localparam int UNITS_W = 15;
    localparam int SEQ_W   = 16;

    // Saturation ranges and reset values of the configuration registers.
    localparam logic [LEN_W-1:0]   WIN_MIN       = 22'd100;
    localparam logic [LEN_W-1:0]   WIN_MAX       = 22'd3600000;
    localparam logic [LEN_W-1:0]   DUR_MIN       = 22'd100;
    localparam logic [LEN_W-1:0]   DUR_MAX       = 22'd3600000;
    localparam logic [IVL_W-1:0]   IVL_MIN       = 13'd20;
    localparam logic [IVL_W-1:0]   IVL_MAX       = 13'd5000;
    localparam logic [LEN_W-1:0]   WIN_RESET     = 22'd3000;
    localparam logic [LEN_W-1:0]   DUR_RESET     = 22'd600;
    localparam logic [UNITS_W-1:0] UNITS_RESET   = 15'd320;

    // Interval unit clamp and the cap on the reported time to the next start.
    localparam logic [UNITS_W-1:0] UNITS_MIN     = 15'h0020;
    localparam logic [UNITS_W-1:0] UNITS_MAX     = 15'h4000;
    localparam logic [TIME_W-1:0]  LEFT_MAX      = 32'd3600000;

    // Reciprocal of five in 2^-18 units; exact for 16-bit dividends.
    localparam logic [15:0] DIV5_MUL   = 16'hCCCD;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic               burst_active;
        logic               burst_started;
        logic               burst_stopped;
        logic [SEQ_W-1:0]   burst_number;
        logic [UNITS_W-1:0] interval_units;
        logic [LEN_W-1:0]   cycle_left_ms;
        logic [LEN_W-1:0]   burst_left_ms;
    } t_out_item;

    // Configuration as seen by the scheduling logic.
    typedef struct packed {
        logic [LEN_W-1:0]   window_len_ms;
        logic [LEN_W-1:0]   burst_len_ms;
        logic [UNITS_W-1:0] interval_units;
        logic               sched_enable;
    } t_cfg;

endpackage

// ===== rtl/pbs_cfg.sv =====
// ============================================================================
// pbs_cfg - configuration registers
// Saturates each write to its legal range. The advertising interval is kept
// already converted to 0.625 ms units, rounded up and clamped.
// ============================================================================
module pbs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0] i_data,
    output pbs_pkg::t_cfg                  o_cfg
);
    import pbs_pkg::*;

    logic [LEN_W-1:0]   r_window;
    logic [LEN_W-1:0]   r_burst;
    logic [UNITS_W-1:0] r_units;
    logic               r_enable;

    logic [LEN_W-1:0]   wr_len;
    logic [LEN_W-1:0]   win_sat;
    logic [LEN_W-1:0]   dur_sat;
    logic [IVL_W-1:0]   wr_ivl;
    logic [IVL_W-1:0]   ivl_sat;
    logic [15:0]        eighths;
    logic [31:0]        div_prod;
    logic [UNITS_W-1:0] units_raw;
    logic [UNITS_W-1:0] units_sat;

    // Saturate the incoming lengths.
    assign wr_len  = i_data[LEN_W-1:0];
    assign win_sat = (wr_len < WIN_MIN) ? WIN_MIN : ((wr_len > WIN_MAX) ? WIN_MAX : wr_len);
    assign dur_sat = (wr_len < DUR_MIN) ? DUR_MIN : ((wr_len > DUR_MAX) ? DUR_MAX : wr_len);
    assign wr_ivl  = i_data[IVL_W-1:0];
    assign ivl_sat = (wr_ivl < IVL_MIN) ? IVL_MIN : ((wr_ivl > IVL_MAX) ? IVL_MAX : wr_ivl);

    // Units of 0.625 ms rounded up: (ms * 8 + 4) / 5, the divide done by
    // multiplying with the reciprocal of five.
    assign eighths   = {ivl_sat, 3'b000} + 16'd4;
    assign div_prod  = eighths * DIV5_MUL;
    assign units_raw = UNITS_W'(div_prod[31:DIV5_SHIFT]);
    assign units_sat = (units_raw < UNITS_MIN) ? UNITS_MIN :
                       ((units_raw > UNITS_MAX) ? UNITS_MAX : units_raw);

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_RESET;
            r_burst  <= DUR_RESET;
            r_units  <= UNITS_RESET;
            r_enable <= 1'b1;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_WINDOW:   r_window <= win_sat;
                CFG_BURST:    r_burst  <= dur_sat;
                CFG_INTERVAL: r_units  <= units_sat;
                CFG_ENABLE:   r_enable <= i_data[0];
                default:      r_enable <= r_enable;
            endcase
        end
    end

    assign o_cfg.window_len_ms  = r_window;
    assign o_cfg.burst_len_ms   = r_burst;
    assign o_cfg.interval_units = r_units;
    assign o_cfg.sched_enable   = r_enable;

endmodule

// ===== rtl/pbs_core.sv =====
// ============================================================================
// pbs_core - burst scheduling state and step logic
// Holds the schedule state and works out one step for the registered input
// transaction. The state advances only when i_step is high.
// ============================================================================
module pbs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  pbs_pkg::t_in_item  i_item,
    input  pbs_pkg::t_cfg      i_cfg,
    output pbs_pkg::t_out_item o_result
);
    import pbs_pkg::*;

    logic              r_started_up;
    logic              r_in_burst;
    logic [TIME_W-1:0] r_begin;
    logic [TIME_W-1:0] r_end;
    logic [TIME_W-1:0] r_next;
    logic [SEQ_W-1:0]  r_seq;

    logic              n_started_up;
    logic              n_in_burst;
    logic [TIME_W-1:0] n_begin;
    logic [TIME_W-1:0] n_end;
    logic [TIME_W-1:0] n_next;
    logic [SEQ_W-1:0]  n_seq;

    logic              en;
    logic [TIME_W-1:0] now;
    logic [LEN_W-1:0]  dur;
    logic [TIME_W-1:0] win32;
    logic [TIME_W-1:0] dur32;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] past_end;
    logic [TIME_W-1:0] next_stop;
    logic [TIME_W-1:0] past_stop;
    logic [TIME_W-1:0] until_stop;
    logic [TIME_W-1:0] past_next;
    logic [TIME_W-1:0] to_next;
    logic [TIME_W-1:0] win_rest;
    logic [TIME_W-1:0] dur_rest;
    logic [TIME_W-1:0] until_sel;
    logic              do_start;
    logic              stopped;
    logic [LEN_W-1:0]  cycle_left;
    logic [LEN_W-1:0]  burst_left;

    // Effective burst length is capped at the window.
    assign en    = i_cfg.sched_enable;
    assign now   = i_item.now_ms;
    assign dur   = (i_cfg.burst_len_ms > i_cfg.window_len_ms) ? i_cfg.window_len_ms
                                                              : i_cfg.burst_len_ms;
    assign win32 = TIME_W'(i_cfg.window_len_ms);
    assign dur32 = TIME_W'(dur);

    // Wrap-safe time differences, all formed in parallel from the state.
    assign elapsed    = now - r_begin;
    assign past_end   = now - r_end;
    assign next_stop  = r_begin + win32;
    assign past_stop  = now - next_stop;
    assign until_stop = next_stop - now;
    assign past_next  = now - r_next;
    assign to_next    = r_next - now;
    assign win_rest   = win32 - elapsed;
    assign dur_rest   = dur32 - elapsed;

    // Next state for one step.
    always_comb begin
        n_started_up = r_started_up;
        n_in_burst   = r_in_burst;
        n_begin      = r_begin;
        n_end        = r_end;
        n_next       = r_next;
        n_seq        = r_seq;
        do_start     = 1'b0;
        stopped      = 1'b0;
        until_sel    = to_next;
        if (i_item.op == OP_RESTART) begin
            n_started_up = 1'b1;
            stopped      = r_in_burst;
            n_in_burst   = 1'b0;
            n_next       = now;
            n_begin      = '0;
            n_end        = '0;
            do_start     = en;
        end else if (r_started_up) begin
            if (!en) begin
                stopped    = r_in_burst;
                n_in_burst = 1'b0;
                n_next     = now;
            end else if (r_in_burst) begin
                // The burst ends once its stop time is reached; the next
                // start may already be due in the same step.
                if (!past_end[TIME_W-1]) begin
                    stopped    = 1'b1;
                    n_in_burst = 1'b0;
                    n_next     = next_stop;
                    until_sel  = until_stop;
                    do_start   = !past_stop[TIME_W-1];
                end
            end else begin
                do_start = !past_next[TIME_W-1];
            end
        end
        if (do_start) begin
            n_in_burst = 1'b1;
            n_begin    = now;
            n_end      = now + dur32;
            n_seq      = r_seq + 1'b1;
        end
    end

    // Remaining times reported with the step.
    always_comb begin
        cycle_left = '0;
        burst_left = '0;
        if (n_started_up && en) begin
            if (do_start) begin
                cycle_left = i_cfg.window_len_ms;
                burst_left = dur;
            end else if (n_in_burst) begin
                cycle_left = (elapsed < win32) ? win_rest[LEN_W-1:0] : '0;
                burst_left = (elapsed < dur32) ? dur_rest[LEN_W-1:0] : '0;
            end else if ((until_sel != '0) && !until_sel[TIME_W-1]) begin
                cycle_left = (until_sel > LEFT_MAX) ? LEFT_MAX[LEN_W-1:0]
                                                    : until_sel[LEN_W-1:0];
            end
        end
    end

    // Schedule state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started_up <= 1'b0;
            r_in_burst   <= 1'b0;
            r_begin      <= '0;
            r_end        <= '0;
            r_next       <= '0;
            r_seq        <= '0;
        end else if (i_step) begin
            r_started_up <= n_started_up;
            r_in_burst   <= n_in_burst;
            r_begin      <= n_begin;
            r_end        <= n_end;
            r_next       <= n_next;
            r_seq        <= n_seq;
        end
    end

    assign o_result.burst_active   = n_in_burst;
    assign o_result.burst_started  = do_start;
    assign o_result.burst_stopped  = stopped;
    assign o_result.burst_number   = n_seq;
    assign o_result.interval_units = i_cfg.interval_units;
    assign o_result.cycle_left_ms  = cycle_left;
    assign o_result.burst_left_ms  = burst_left;

endmodule

// ===== rtl/periodic_burst_scheduler_top.sv =====
// ============================================================================
// periodic_burst_scheduler_top - periodic advertising burst scheduler
// Starts one burst per window on a wrapping millisecond clock and reports
// burst flags, sequence number, interval units and remaining times per step.
// ============================================================================
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  ---------------------------------
//   in       i_in_valid / o_in_ready   i_in_item  (op, now_ms)
//   out      o_out_valid / i_out_ready o_out_item (flags, number, times)
//   cfg      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An accepted transaction lands in the input register, is evaluated and its
// result is captured in the output register; one transaction per cycle is
// sustained while the output is not stalled. A stalled output holds the
// result and the input register drains into it as soon as it is taken.
// Reset is synchronous and active low; configuration writes are always ready.
// ============================================================================
module periodic_burst_scheduler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pbs_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pbs_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pbs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      step;
    t_cfg      cfg;
    t_out_item result;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    pbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The held transaction moves on when the output register is free or
    // being emptied in this cycle.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    pbs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/pbs_checker.sv =====
// ============================================================================
// pbs_checker - port-level checks for the burst scheduler
// Watches the result channel for stalled-data stability and for result
// fields that contradict each other.
// ============================================================================
module pbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pbs_pkg::t_out_item o_out_item
);
    import pbs_pkg::*;

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A burst that started in this step is running after it.
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.burst_started |-> o_out_item.burst_active)
        else $error("burst started but not active");

    // No time left in a burst when none runs.
    a_idle_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.burst_active |-> o_out_item.burst_left_ms == '0)
        else $error("burst time left with no burst running");

    // The burst never outlasts its window.
    a_left_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.burst_left_ms <= o_out_item.cycle_left_ms)
        else $error("burst time left exceeds cycle time left");

    // Interval units stay within the clamp range.
    a_units_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.interval_units >= UNITS_MIN &&
                        o_out_item.interval_units <= UNITS_MAX)
        else $error("interval units out of range");

endmodule

bind periodic_burst_scheduler_top pbs_checker u_pbs_checker (.*);
